// ----- hdl/ltq_pkg.sv -----
package ltq_pkg;

  localparam int POS_BITS    = 10;
  localparam int SPAN_BITS   = 10;
  localparam int MARGIN_BITS = 9;
  localparam int LCONF_BITS  = 8;
  localparam int STREAK_BITS = 4;
  localparam int LOST_BITS   = 16;
  localparam int SIDE_BITS   = 2;
  localparam int SPOS_BITS   = 11;
  localparam int ADDR_BITS   = 5;
  localparam int DATA_BITS   = 32;

  typedef logic [POS_BITS-1:0]    pos_t;
  typedef logic [SPAN_BITS-1:0]   span_t;
  typedef logic [LOST_BITS-1:0]   lost_t;
  typedef logic [STREAK_BITS-1:0] streak_t;
  typedef logic [SIDE_BITS-1:0]   side_t;
  typedef logic [SPOS_BITS-1:0]   spos_t;

  localparam lost_t   LOST_MAX   = '1;
  localparam streak_t STREAK_MAX = '1;

  localparam pos_t POS_RST = pos_t'(60);

  localparam side_t SIDE_NONE  = 2'b00;
  localparam side_t SIDE_RIGHT = 2'b01;
  localparam side_t SIDE_LEFT  = 2'b11;

  localparam spos_t SPOS_NONE = '1;

  typedef enum logic [1:0] {
    CONF_UNRELIABLE = 2'd0,
    CONF_UNCERTAIN  = 2'd1,
    CONF_CERTAIN    = 2'd2
  } conf_t;

  typedef enum logic [1:0] {
    SHAPE_NONE  = 2'd0,
    SHAPE_T     = 2'd1,
    SHAPE_LEFT  = 2'd2,
    SHAPE_RIGHT = 2'd3
  } shape_kind_t;

  typedef enum logic [2:0] {
    REG_LINE_SPAN     = 3'd0,
    REG_EDGE_MARGIN   = 3'd1,
    REG_MAX_JUMP      = 3'd2,
    REG_LOST_CONFIRM  = 3'd3,
    REG_REACQ_CONFIRM = 3'd4,
    REG_MIN_THICKNESS = 3'd5,
    REG_DELTA_FLOOR   = 3'd6
  } reg_idx_t;

  typedef struct packed {
    span_t                  line_span;
    logic [MARGIN_BITS-1:0] edge_margin;
    pos_t                   max_jump;
    logic [LCONF_BITS-1:0]  lost_confirm;
    streak_t                reacquire_confirm;
    pos_t                   min_thickness;
    pos_t                   delta_floor;
  } cfg_t;

  typedef struct packed {
    logic point_found;
    pos_t point_x;
    logic detect_shapes;
    logic shape_found;
    pos_t shape_x;
    pos_t shape_y;
    pos_t shape_thickness;
  } item_t;

  typedef struct packed {
    conf_t confidence;
    pos_t  line_pos;
    logic  line_found;
    logic  measurement_valid;
    lost_t lost_frame_count;
    side_t last_side;
  } track_res_t;

  typedef struct packed {
    shape_kind_t kind;
    spos_t       pos_x;
    spos_t       pos_y;
  } shape_res_t;

  // span/6 as multiply by 683/4096; exact for spans up to 1023
  localparam int DIV6_MUL   = 683;
  localparam int DIV6_SHIFT = 12;
  localparam int DIV6_BITS  = SPAN_BITS + DIV6_SHIFT - 2;

  function automatic span_t div6(input span_t v);
    logic [DIV6_BITS-1:0] prod;
    prod = DIV6_BITS'(v) * DIV6_BITS'(DIV6_MUL);
    return span_t'(prod[DIV6_BITS-1:DIV6_SHIFT]);
  endfunction

endpackage

// ----- hdl/ltq_cfg.sv -----
module ltq_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ltq_pkg::ADDR_BITS-1:0] paddr,
  input  logic [ltq_pkg::DATA_BITS-1:0] pwdata,
  output logic [ltq_pkg::DATA_BITS-1:0] prdata,
  output ltq_pkg::cfg_t                 cfg
);
  import ltq_pkg::*;

  reg_idx_t idx;
  logic     wr;

  assign idx = reg_idx_t'(paddr[ADDR_BITS-1:2]);
  assign wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.line_span         <= span_t'(120);
      cfg.edge_margin       <= MARGIN_BITS'(20);
      cfg.max_jump          <= pos_t'(40);
      cfg.lost_confirm      <= LCONF_BITS'(1);
      cfg.reacquire_confirm <= streak_t'(2);
      cfg.min_thickness     <= pos_t'(15);
      cfg.delta_floor       <= pos_t'(14);
    end else if (wr) begin
      unique case (idx)
        REG_LINE_SPAN:     cfg.line_span         <= pwdata[SPAN_BITS-1:0];
        REG_EDGE_MARGIN:   cfg.edge_margin       <= pwdata[MARGIN_BITS-1:0];
        REG_MAX_JUMP:      cfg.max_jump          <= pwdata[POS_BITS-1:0];
        REG_LOST_CONFIRM:  cfg.lost_confirm      <= pwdata[LCONF_BITS-1:0];
        REG_REACQ_CONFIRM: cfg.reacquire_confirm <= pwdata[STREAK_BITS-1:0];
        REG_MIN_THICKNESS: cfg.min_thickness     <= pwdata[POS_BITS-1:0];
        REG_DELTA_FLOOR:   cfg.delta_floor       <= pwdata[POS_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_LINE_SPAN:     prdata = DATA_BITS'(cfg.line_span);
      REG_EDGE_MARGIN:   prdata = DATA_BITS'(cfg.edge_margin);
      REG_MAX_JUMP:      prdata = DATA_BITS'(cfg.max_jump);
      REG_LOST_CONFIRM:  prdata = DATA_BITS'(cfg.lost_confirm);
      REG_REACQ_CONFIRM: prdata = DATA_BITS'(cfg.reacquire_confirm);
      REG_MIN_THICKNESS: prdata = DATA_BITS'(cfg.min_thickness);
      REG_DELTA_FLOOR:   prdata = DATA_BITS'(cfg.delta_floor);
      default:           prdata = '0;
    endcase
  end

endmodule

// ----- hdl/ltq_track.sv -----
module ltq_track (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  ltq_pkg::cfg_t       cfg,
  input  logic                point_found,
  input  ltq_pkg::pos_t       point_x,
  output ltq_pkg::track_res_t res
);
  import ltq_pkg::*;

  logic    track_found, track_found_next;
  logic    smooth_hist, smooth_hist_next;
  logic    raw_hist, raw_hist_next;
  logic    valid_flag, valid_flag_next;
  pos_t    smoothed_pos, smoothed_pos_next;
  pos_t    prev_raw, prev_raw_next;
  streak_t reacq, reacq_next;
  lost_t   lost, lost_next;
  side_t   side, side_next;

  logic                 safe, jump, accept, lost_hit;
  lost_t                lost_inc;
  streak_t              streak;
  pos_t                 diff, centre;
  logic [POS_BITS+1:0]  sum;
  logic [SPAN_BITS+1:0] safe_hi;
  conf_t                conf;

  assign lost_inc = (lost == LOST_MAX) ? lost : lost + lost_t'(1);
  assign lost_hit = lost_inc >= LOST_BITS'(cfg.lost_confirm);
  assign diff     = (point_x > prev_raw) ? point_x - prev_raw : prev_raw - point_x;
  assign jump     = raw_hist && (diff > cfg.max_jump);
  // margin < x < span-1-margin, rearranged to stay unsigned
  assign safe_hi  = (SPAN_BITS+2)'(point_x) + (SPAN_BITS+2)'(cfg.edge_margin) + 1'b1;
  assign safe     = (point_x > POS_BITS'(cfg.edge_margin)) &&
                    (safe_hi < (SPAN_BITS+2)'(cfg.line_span));
  assign sum      = ((POS_BITS+2)'(point_x) << 1) + (POS_BITS+2)'(point_x)
                  + (POS_BITS+2)'(smoothed_pos) + (POS_BITS+2)'(2);
  assign centre   = pos_t'(cfg.line_span >> 1);

  always_comb begin
    track_found_next  = track_found;
    smooth_hist_next  = smooth_hist;
    raw_hist_next     = raw_hist;
    valid_flag_next   = valid_flag;
    smoothed_pos_next = smoothed_pos;
    prev_raw_next     = prev_raw;
    reacq_next        = reacq;
    lost_next         = lost;
    side_next         = side;
    conf              = CONF_UNRELIABLE;
    accept            = 1'b0;
    streak            = '0;

    if (!point_found) begin
      valid_flag_next = 1'b0;
      reacq_next      = '0;
      lost_next       = lost_inc;
      if (lost_hit) track_found_next = 1'b0;
    end else begin
      prev_raw_next = point_x;
      raw_hist_next = 1'b1;
      if (!track_found) begin
        streak     = safe ? ((reacq == STREAK_MAX) ? reacq : reacq + streak_t'(1)) : '0;
        reacq_next = streak;
        if (streak >= cfg.reacquire_confirm) begin
          accept = 1'b1;
        end else begin
          valid_flag_next = 1'b0;
          lost_next       = lost_inc;
          conf            = CONF_UNCERTAIN;
        end
      end else begin
        reacq_next = '0;
        if (jump) begin
          valid_flag_next = 1'b0;
          lost_next       = lost_inc;
          if (lost_hit) begin
            track_found_next = 1'b0;
          end else begin
            conf = CONF_UNCERTAIN;
          end
        end else begin
          accept = 1'b1;
        end
      end
    end

    if (accept) begin
      smooth_hist_next  = 1'b1;
      smoothed_pos_next = smooth_hist ? sum[POS_BITS+1:2] : point_x;
      if (smoothed_pos_next < centre) begin
        side_next = SIDE_LEFT;
      end else if (smoothed_pos_next > centre) begin
        side_next = SIDE_RIGHT;
      end
      valid_flag_next  = 1'b1;
      lost_next        = '0;
      track_found_next = 1'b1;
      conf             = CONF_CERTAIN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      track_found  <= 1'b0;
      smooth_hist  <= 1'b0;
      raw_hist     <= 1'b0;
      valid_flag   <= 1'b0;
      smoothed_pos <= POS_RST;
      prev_raw     <= POS_RST;
      reacq        <= '0;
      lost         <= '0;
      side         <= SIDE_NONE;
    end else if (step) begin
      track_found  <= track_found_next;
      smooth_hist  <= smooth_hist_next;
      raw_hist     <= raw_hist_next;
      valid_flag   <= valid_flag_next;
      smoothed_pos <= smoothed_pos_next;
      prev_raw     <= prev_raw_next;
      reacq        <= reacq_next;
      lost         <= lost_next;
      side         <= side_next;
    end
  end

  assign res.confidence        = conf;
  assign res.line_pos          = smoothed_pos_next;
  assign res.line_found        = track_found_next;
  assign res.measurement_valid = valid_flag_next;
  assign res.lost_frame_count  = lost_next;
  assign res.last_side         = side_next;

endmodule

// ----- hdl/ltq_shape.sv -----
module ltq_shape (
  input  ltq_pkg::cfg_t       cfg,
  input  ltq_pkg::item_t      item,
  input  ltq_pkg::conf_t      conf,
  output ltq_pkg::shape_res_t res
);
  import ltq_pkg::*;

  span_t sixth, limit;
  pos_t  delta;
  logic  take;

  assign sixth = div6(cfg.line_span);
  assign limit = (SPAN_BITS'(cfg.delta_floor) > sixth) ? SPAN_BITS'(cfg.delta_floor) : sixth;
  assign delta = (item.shape_x > item.point_x) ? item.shape_x - item.point_x
                                               : item.point_x - item.shape_x;
  assign take  = item.detect_shapes && item.shape_found && item.point_found &&
                 (conf == CONF_CERTAIN) && (item.shape_thickness >= cfg.min_thickness);

  always_comb begin
    res.kind  = SHAPE_NONE;
    res.pos_x = SPOS_NONE;
    res.pos_y = SPOS_NONE;
    if (take) begin
      res.pos_y = SPOS_BITS'(item.shape_y);
      if (SPAN_BITS'(delta) <= limit) begin
        res.kind  = SHAPE_T;
        res.pos_x = SPOS_BITS'(item.shape_x);
      end else begin
        res.kind  = (item.shape_x < item.point_x) ? SHAPE_LEFT : SHAPE_RIGHT;
        res.pos_x = SPOS_BITS'(item.point_x);
      end
    end
  end

endmodule

// ----- hdl/line_track_qualifier.sv -----
// channel | direction | handshake          | payload
// in      | input     | in_valid/in_ready   | point_found, point_x, detect_shapes, shape_found,
//         |           |                     | shape_x, shape_y, shape_thickness
// out     | output    | out_valid/out_ready | confidence, line_pos, line_found, measurement_valid,
//         |           |                     | lost_frame_count, last_side, shape_kind,
//         |           |                     | shape_pos_x, shape_pos_y
// cfg     | APB       | psel/penable/pready | paddr, pwdata, prdata
//
// Result word passes through the input register, then the result register.
// One word per cycle sustained while out_ready stays high; track state updates in the same cycle the word
// moves from the input register into the result register.
// Synchronous active-high reset restores the register defaults and the track state.
// A stalled output holds its word; the input register keeps one more word meanwhile.
module line_track_qualifier (
  input  logic                          clk,
  input  logic                          rst,

  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          point_found,
  input  ltq_pkg::pos_t                 point_x,
  input  logic                          detect_shapes,
  input  logic                          shape_found,
  input  ltq_pkg::pos_t                 shape_x,
  input  ltq_pkg::pos_t                 shape_y,
  input  ltq_pkg::pos_t                 shape_thickness,

  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    confidence,
  output ltq_pkg::pos_t                 line_pos,
  output logic                          line_found,
  output logic                          measurement_valid,
  output ltq_pkg::lost_t                lost_frame_count,
  output ltq_pkg::side_t                last_side,
  output logic [1:0]                    shape_kind,
  output ltq_pkg::spos_t                shape_pos_x,
  output ltq_pkg::spos_t                shape_pos_y,

  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ltq_pkg::ADDR_BITS-1:0] paddr,
  input  logic [ltq_pkg::DATA_BITS-1:0] pwdata,
  output logic [ltq_pkg::DATA_BITS-1:0] prdata,
  output logic                          pready
);
  import ltq_pkg::*;

  cfg_t       cfg;
  item_t      item;
  logic       item_valid;
  logic       advance;
  track_res_t trk;
  shape_res_t shp;

  assign pready   = 1'b1;
  assign advance  = item_valid && (!out_valid || out_ready);
  assign in_ready = !item_valid || advance;

  ltq_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  ltq_track u_track (
    .clk         (clk),
    .rst         (rst),
    .step        (advance),
    .cfg         (cfg),
    .point_found (item.point_found),
    .point_x     (item.point_x),
    .res         (trk)
  );

  ltq_shape u_shape (
    .cfg  (cfg),
    .item (item),
    .conf (trk.confidence),
    .res  (shp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item.point_found     <= point_found;
      item.point_x         <= point_x;
      item.detect_shapes   <= detect_shapes;
      item.shape_found     <= shape_found;
      item.shape_x         <= shape_x;
      item.shape_y         <= shape_y;
      item.shape_thickness <= shape_thickness;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      confidence        <= trk.confidence;
      line_pos          <= trk.line_pos;
      line_found        <= trk.line_found;
      measurement_valid <= trk.measurement_valid;
      lost_frame_count  <= trk.lost_frame_count;
      last_side         <= trk.last_side;
      shape_kind        <= shp.kind;
      shape_pos_x       <= shp.pos_x;
      shape_pos_y       <= shp.pos_y;
    end
  end

endmodule
